// ----- hdl/smm_pkg.sv -----
// ----------------------------------------------------------------------------
// smm_pkg
// Types and constants shared by the square matrix multiplier: request codes,
// controller states, and the token and result words that travel the chain.
// ----------------------------------------------------------------------------
package smm_pkg;

  localparam int IDX_PORT_W = 3;   // row and column fields of the ports
  localparam int ELEM_W     = 16;  // one matrix element
  localparam int ACC_W      = 35;  // full-precision dot product
  localparam int SIZE_W     = 4;   // size register

  typedef enum logic [1:0] {
    REQ_WRITE_A = 2'd0,
    REQ_WRITE_B = 2'd1,
    REQ_COMPUTE = 2'd2
  } req_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  // One step of a dot product, handed from cell to cell.
  typedef struct packed {
    logic                    valid;
    logic                    first;     // first term of the dot product
    logic                    last;      // last term of the dot product
    logic                    row_last;  // term belongs to the final row
    logic [IDX_PORT_W-1:0]   row;
    logic [IDX_PORT_W-1:0]   k;
    logic signed [ELEM_W-1:0] a;
  } token_t;

  // A finished product element leaving a cell.
  typedef struct packed {
    logic                    valid;
    logic                    last;
    logic [IDX_PORT_W-1:0]   row;
    logic signed [ACC_W-1:0] value;
  } result_t;

endpackage

// ----- hdl/smm_ram.sv -----
// ----------------------------------------------------------------------------
// smm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module smm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/smm_cell.sv -----
// ----------------------------------------------------------------------------
// smm_cell
// One column cell: holds a column of the right matrix and accumulates the dot
// product for that column while row tokens pass through on their way along.
// ----------------------------------------------------------------------------
module smm_cell #(
  parameter int MAX_SIZE = 8,
  parameter int COLUMN   = 0,
  localparam int IDX_W   = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic [IDX_W-1:0]              size_last,
  input  logic                          b_we,
  input  logic [IDX_W-1:0]              b_waddr,
  input  logic [smm_pkg::ELEM_W-1:0]    b_wdata,
  input  smm_pkg::token_t               tok_in,
  output smm_pkg::token_t               tok_out,
  output smm_pkg::result_t              res
);

  import smm_pkg::*;

  localparam logic [IDX_W-1:0] COL_IDX = IDX_W'(COLUMN);

  token_t                   tok_q;
  logic [ELEM_W-1:0]        b_rdata;
  logic signed [ACC_W-1:0]  acc;
  logic signed [2*ELEM_W-1:0] prod;
  logic signed [ACC_W-1:0]  sum;
  logic                     in_range;

  // Read B[k][COLUMN] as the token arrives; the registered data meets the token in tok_q.
  smm_ram #(
    .WIDTH(ELEM_W),
    .DEPTH(MAX_SIZE)
  ) u_col_ram (
    .clk  (clk),
    .we   (b_we),
    .waddr(b_waddr),
    .wdata(b_wdata),
    .re   (adv),
    .raddr(tok_in.k[IDX_W-1:0]),
    .rdata(b_rdata)
  );

  assign prod     = tok_q.a * $signed(b_rdata);
  assign sum      = (tok_q.first ? {ACC_W{1'b0}} : acc) + ACC_W'(prod);
  assign in_range = (COL_IDX <= size_last);
  assign tok_out  = tok_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q     <= '0;
      res.valid <= 1'b0;
    end else if (adv) begin
      tok_q     <= tok_in;
      res.valid <= tok_q.valid && tok_q.last && in_range;
    end
    if (adv) begin
      if (tok_q.valid) begin
        acc <= sum;
      end
      res.last  <= tok_q.row_last && (COL_IDX == size_last);
      res.row   <= tok_q.row;
      res.value <= sum;
    end
  end

endmodule

// ----- hdl/square_matrix_multiply.sv -----
// ----------------------------------------------------------------------------
// square_matrix_multiply
// Signed integer square matrix multiplier, sizes 1 to MAX_SIZE.
// ----------------------------------------------------------------------------
// Write words store one element of A or B. A compute word walks row r and
// step k of A, one A element per cycle while the output is not stalled,
// from the single read port of the A store, and sends it down a chain of
// MAX_SIZE column cells; each cell multiplies it by its own B[k][c] and
// accumulates. A run for size n therefore issues n*n A elements; products
// leave one per cycle while the output is not stalled, in row-major order,
// the last one flagged. The next word is taken once the chain has drained.
// A stall on the output freezes the whole chain. Size values of 0 act as 1
// and values above MAX_SIZE act as MAX_SIZE.
// ----------------------------------------------------------------------------
module square_matrix_multiply #(
  parameter int MAX_SIZE = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [smm_pkg::SIZE_W-1:0]           cfg_data,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           req_type,
  input  logic [smm_pkg::IDX_PORT_W-1:0]       row_index,
  input  logic [smm_pkg::IDX_PORT_W-1:0]       column_index,
  input  logic signed [smm_pkg::ELEM_W-1:0]    element_value,
  // product channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [smm_pkg::IDX_PORT_W-1:0]       out_row,
  output logic [smm_pkg::IDX_PORT_W-1:0]       out_column,
  output logic signed [smm_pkg::ACC_W-1:0]     product_value,
  output logic                                 last_element
);

  import smm_pkg::*;

  localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'((MAX_SIZE < 8) ? MAX_SIZE : 8);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_SIZE);

  state_t              state, state_next;
  logic [SIZE_W-1:0]   matrix_size;
  logic [SIZE_W-1:0]   size_eff;
  logic [IDX_W-1:0]    size_last;
  logic [IDX_W-1:0]    r_cnt;
  logic [IDX_W-1:0]    k_cnt;
  logic                k_done;
  logic                r_done;
  logic                adv;
  logic                accept;
  logic                idx_ok;
  logic                a_we;
  logic                b_we;
  logic                issue_valid;
  logic                chain_busy;
  logic [AW-1:0]       a_waddr;
  logic [AW-1:0]       a_raddr;
  logic [ELEM_W-1:0]   a_rdata;
  token_t              issue;
  token_t              tok0;
  token_t              tok [MAX_SIZE+1];
  result_t             res [MAX_SIZE];
  logic                sel_valid;
  logic                sel_last;
  logic [IDX_PORT_W-1:0] sel_row;
  logic [IDX_PORT_W-1:0] sel_col;
  logic signed [ACC_W-1:0] sel_value;

  // The whole chain and the output register move together.
  assign adv = !out_valid || out_ready;

  // Configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      matrix_size <= cfg_data;
    end
  end

  always_comb begin
    if (matrix_size == '0) begin
      size_eff = SIZE_W'(1);
    end else if (matrix_size > SIZE_MAX) begin
      size_eff = SIZE_MAX;
    end else begin
      size_eff = matrix_size;
    end
  end

  assign size_last = IDX_W'(size_eff - SIZE_W'(1));

  // Element writes
  assign accept  = in_valid && in_ready;
  assign idx_ok  = (int'(row_index) < MAX_SIZE) && (int'(column_index) < MAX_SIZE);
  assign a_we    = accept && (req_type == REQ_WRITE_A) && idx_ok;
  assign b_we    = accept && (req_type == REQ_WRITE_B) && idx_ok;
  assign a_waddr = AW'(int'(row_index) * MAX_SIZE + int'(column_index));
  assign a_raddr = AW'(int'(r_cnt) * MAX_SIZE + int'(k_cnt));

  smm_ram #(
    .WIDTH(ELEM_W),
    .DEPTH(DEPTH)
  ) u_a_ram (
    .clk  (clk),
    .we   (a_we),
    .waddr(a_waddr),
    .wdata(element_value),
    .re   (adv),
    .raddr(a_raddr),
    .rdata(a_rdata)
  );

  // Sequencer
  assign k_done = (k_cnt == size_last);
  assign r_done = (r_cnt == size_last);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (req_type == REQ_COMPUTE)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (adv && k_done && r_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    issue_valid = 1'b0;
    unique case (state)
      ST_IDLE: in_ready    = !chain_busy;
      ST_RUN:  issue_valid = 1'b1;
      default: begin
        in_ready    = 1'b0;
        issue_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      r_cnt <= '0;
      k_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        r_cnt <= '0;
        k_cnt <= '0;
      end else if (adv) begin
        if (k_done) begin
          k_cnt <= '0;
          r_cnt <= r_cnt + IDX_W'(1);
        end else begin
          k_cnt <= k_cnt + IDX_W'(1);
        end
      end
    end
  end

  always_comb begin
    issue          = '0;
    issue.valid    = issue_valid;
    issue.first    = (k_cnt == '0);
    issue.last     = k_done;
    issue.row_last = r_done;
    issue.row      = IDX_PORT_W'(r_cnt);
    issue.k        = IDX_PORT_W'(k_cnt);
  end

  // Register the token so it meets the A element from the registered store read.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok0 <= '0;
    end else if (adv) begin
      tok0 <= issue;
    end
  end

  always_comb begin
    tok[0]   = tok0;
    tok[0].a = $signed(a_rdata);
  end

  // Column cells
  for (genvar c = 0; c < MAX_SIZE; c++) begin : g_cell
    smm_cell #(
      .MAX_SIZE(MAX_SIZE),
      .COLUMN  (c)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .size_last(size_last),
      .b_we     (b_we && (column_index == IDX_PORT_W'(c))),
      .b_waddr  (row_index[IDX_W-1:0]),
      .b_wdata  (element_value),
      .tok_in   (tok[c]),
      .tok_out  (tok[c+1]),
      .res      (res[c])
    );
  end

  always_comb begin
    chain_busy = tok0.valid;
    for (int c = 1; c <= MAX_SIZE; c++) begin
      chain_busy = chain_busy | tok[c].valid;
    end
  end

  // At most one cell finishes in any cycle; pick it.
  always_comb begin
    sel_valid = 1'b0;
    sel_last  = 1'b0;
    sel_row   = '0;
    sel_col   = '0;
    sel_value = '0;
    for (int c = 0; c < MAX_SIZE; c++) begin
      if (res[c].valid) begin
        sel_valid = 1'b1;
        sel_last  = res[c].last;
        sel_row   = res[c].row;
        sel_col   = IDX_PORT_W'(c);
        sel_value = res[c].value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= sel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_row       <= sel_row;
      out_column    <= sel_col;
      product_value <= sel_value;
      last_element  <= sel_last;
    end
  end

endmodule
